@@ design/grs_pkg.sv @@
`default_nettype none

package grs_pkg;

    localparam int GLYPH_SLOTS  = 128;
    localparam int BITMAP_BYTES = 4096;
    localparam int SLOT_W       = $clog2(GLYPH_SLOTS);
    localparam int BADDR_W      = $clog2(BITMAP_BYTES);

    localparam logic [1:0] ACT_GLYPH = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_PEN   = 2'd2;
    localparam logic [1:0] ACT_DRAW  = 2'd3;

    localparam logic [2:0] REG_COLUMNS = 3'd0;
    localparam logic [2:0] REG_ROWS    = 3'd1;
    localparam logic [2:0] REG_CMAJOR  = 3'd2;
    localparam logic [2:0] REG_COUNT   = 3'd3;
    localparam logic [2:0] REG_FIRST   = 3'd4;
    localparam logic [2:0] REG_END     = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic [11:0]        table_address;
        logic [11:0]        glyph_offset;
        logic [3:0]         glyph_width;
        logic [3:0]         glyph_height;
        logic [3:0]         glyph_advance;
        logic [7:0]         bitmap_byte;
        logic signed [7:0]  pen_column;
        logic signed [7:0]  pen_row;
        logic [7:0]         char_code;
        logic [23:0]        pixel_color;
    } item_t;

    typedef struct packed {
        logic [9:0]  led_index;
        logic [23:0] led_color;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [5:0]  columns;
        logic [5:0]  rows;
        logic        column_major;
        logic [10:0] modulus;
    } panel_t;

    typedef struct packed {
        logic [11:0] offset;
        logic [3:0]  width;
        logic [3:0]  height;
        logic [3:0]  advance;
    } glyph_t;

    typedef struct packed {
        logic busy;
        logic pend_valid;
    } status_t;

endpackage

`default_nettype wire

@@ design/grs_front.sv @@
`default_nettype none

module grs_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire grs_pkg::item_t item,
    input  wire logic [7:0]     first_code,
    input  wire logic [7:0]     end_code,
    output logic                q_valid,
    input  wire logic           q_ready,
    output grs_pkg::item_t      q_head
);

    grs_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    grs_pkg::item_t cmd;
    logic           keep;
    logic           push, pop;

    // Draw requests outside the font are accepted and dropped here.
    always_comb
    begin
        cmd  = item;
        keep = 1'b1;
        if (item.action == grs_pkg::ACT_DRAW)
        begin
            keep = (item.char_code >= first_code) && (item.char_code < end_code);
            cmd.table_address = {4'd0, item.char_code - first_code};
        end
    end

    assign item_ready = (count_reg != 2'd2);
    assign q_valid    = (count_reg != 2'd0);
    assign q_head     = slot_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready && keep;
    assign pop        = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/grs_back.sv @@
`default_nettype none

module grs_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire grs_pkg::item_t  q_head,
    input  wire grs_pkg::panel_t panel,
    output logic                 pixel_valid,
    input  wire logic            pixel_ready,
    output grs_pkg::pixel_t      pixel,
    output grs_pkg::status_t     status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GLYPH = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_MOD0  = 3'd3;
    localparam logic [2:0] S_MOD1  = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    grs_pkg::glyph_t gmem [grs_pkg::GLYPH_SLOTS];
    logic [7:0]      bmem [grs_pkg::BITMAP_BYTES];

    grs_pkg::glyph_t gdata_reg;
    logic [7:0]      bdata_reg;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  pen_x_reg, pen_x_next;
    logic [7:0]  pen_y_reg, pen_y_next;
    logic [23:0] color_reg, color_next;
    logic [3:0]  wmax_reg, wmax_next;
    logic [3:0]  hmax_reg, hmax_next;
    logic [3:0]  adv_reg, adv_next;
    logic [2:0]  col_reg, col_next;
    logic [2:0]  row_reg, row_next;
    logic [7:0]  mask_reg, mask_next;
    logic        done_reg, done_next;
    logic [grs_pkg::BADDR_W-1:0] baddr_reg, baddr_next;
    logic        neg_reg, neg_next;
    logic [14:0] rem_reg, rem_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [9:0]  pend_index_reg, pend_index_next;
    logic        out_valid_reg, out_valid_next;
    grs_pkg::pixel_t out_reg, out_next;

    logic        pop, gwrite, bwrite, bread;
    logic        out_free;
    logic [7:0]  px, py;
    logic signed [15:0] xs, ys, cols16, rows16, pos;
    logic signed [14:0] prod;
    logic [3:0]  wclip, hclip;
    logic        at_row_end, at_end;
    logic [10:0] rmod;
    logic [9:0]  idx;

    function automatic logic [14:0] mod_steps(input logic [14:0] rem_in,
                                              input logic [10:0] n,
                                              input logic [3:0] top);
        logic [25:0] r;
        logic [25:0] d;
        r = {11'd0, rem_in};
        for (int j = 0; j < 8; j++)
        begin
            if (int'(top) >= j)
            begin
                d = {15'd0, n} << (int'(top) - j);
                if (r >= d)
                begin
                    r = r - d;
                end
            end
        end
        return r[14:0];
    endfunction

    assign q_ready     = (state_reg == S_IDLE);
    assign pop         = q_valid && q_ready;
    assign out_free    = !out_valid_reg || pixel_ready;
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;
    assign status      = '{busy: (state_reg != S_IDLE), pend_valid: pend_valid_reg};

    assign gwrite = pop && (q_head.action == grs_pkg::ACT_GLYPH);
    assign bwrite = pop && (q_head.action == grs_pkg::ACT_BYTE);
    assign bread  = (state_reg == S_BIT) && (mask_reg == 8'd0);

    always_ff @(posedge clk)
    begin
        if (gwrite)
        begin
            gmem[grs_pkg::SLOT_W'(q_head.table_address)] <=
                '{offset: q_head.glyph_offset, width: q_head.glyph_width,
                  height: q_head.glyph_height, advance: q_head.glyph_advance};
        end
        gdata_reg <= gmem[grs_pkg::SLOT_W'(q_head.table_address)];
    end

    always_ff @(posedge clk)
    begin
        if (bwrite)
        begin
            bmem[grs_pkg::BADDR_W'(q_head.table_address)] <= q_head.bitmap_byte;
        end
        if (bread)
        begin
            bdata_reg <= bmem[baddr_reg];
        end
    end

    always_comb
    begin
        px     = pen_x_reg + {5'd0, col_reg};
        py     = pen_y_reg + {5'd0, row_reg};
        xs     = {{8{px[7]}}, px};
        ys     = {{8{py[7]}}, py};
        cols16 = {10'd0, panel.columns};
        rows16 = {10'd0, panel.rows};
        if (!panel.column_major)
        begin
            prod = $signed(py) * $signed({1'b0, panel.columns});
            pos  = {prod[14], prod} + (py[0] ? xs : (cols16 - xs - 16'sd1));
        end
        else
        begin
            prod = $signed(px) * $signed({1'b0, panel.rows});
            pos  = {prod[14], prod} + (px[0] ? (rows16 - ys - 16'sd1) : ys);
        end
        wclip      = (gdata_reg.width > 4'd8) ? 4'd8 : gdata_reg.width;
        hclip      = (gdata_reg.height > 4'd8) ? 4'd8 : gdata_reg.height;
        at_row_end = ({1'b0, col_reg} == wmax_reg - 4'd1);
        at_end     = at_row_end && ({1'b0, row_reg} == hmax_reg - 4'd1);
        rmod       = rem_reg[10:0];
        idx        = (neg_reg && rmod != 11'd0) ? 10'(panel.modulus - rmod) : rmod[9:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        color_next      = color_reg;
        wmax_next       = wmax_reg;
        hmax_next       = hmax_reg;
        adv_next        = adv_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        mask_next       = mask_reg;
        done_next       = done_reg;
        baddr_next      = baddr_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        out_valid_next  = out_valid_reg && !pixel_ready;
        out_next        = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (q_head.action == grs_pkg::ACT_PEN)
                    begin
                        pen_x_next = q_head.pen_column;
                        pen_y_next = q_head.pen_row;
                    end
                    else if (q_head.action == grs_pkg::ACT_DRAW)
                    begin
                        color_next = q_head.pixel_color;
                        state_next = S_GLYPH;
                    end
                end
            end
            S_GLYPH:
            begin
                wmax_next  = wclip;
                hmax_next  = hclip;
                adv_next   = gdata_reg.advance;
                baddr_next = grs_pkg::BADDR_W'(gdata_reg.offset);
                col_next   = 3'd0;
                row_next   = 3'd0;
                mask_next  = 8'd0;
                done_next  = 1'b0;
                state_next = (wclip == 4'd0 || hclip == 4'd0) ? S_FIN : S_BIT;
            end
            S_BIT:
            begin
                if (mask_reg == 8'd0)
                begin
                    mask_next  = 8'h80;
                    baddr_next = baddr_reg + 1'b1;
                end
                else
                begin
                    mask_next = mask_reg >> 1;
                    done_next = at_end;
                    col_next  = at_row_end ? 3'd0 : col_reg + 3'd1;
                    row_next  = at_row_end ? row_reg + 3'd1 : row_reg;
                    neg_next  = pos[15];
                    rem_next  = pos[15] ? 15'(-pos) : pos[14:0];
                    if ((bdata_reg & mask_reg) != 8'd0)
                    begin
                        state_next = S_MOD0;
                    end
                    else if (at_end)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MOD0:
            begin
                rem_next   = mod_steps(rem_reg, panel.modulus, 4'd14);
                state_next = S_MOD1;
            end
            S_MOD1:
            begin
                rem_next   = mod_steps(rem_reg, panel.modulus, 4'd6);
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '{led_index: pend_index_reg, led_color: color_reg,
                                     last_pixel: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_index_next = idx;
                    state_next      = done_reg ? S_FIN : S_BIT;
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '{led_index: pend_index_reg, led_color: color_reg,
                                     last_pixel: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    pen_x_next      = pen_x_reg + {4'd0, adv_reg};
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pen_x_reg      <= 8'd0;
            pen_y_reg      <= 8'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg      <= color_next;
        wmax_reg       <= wmax_next;
        hmax_reg       <= hmax_next;
        adv_reg        <= adv_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        mask_reg       <= mask_next;
        done_reg       <= done_next;
        baddr_reg      <= baddr_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        pend_index_reg <= pend_index_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

@@ design/glyph_rasterizer_serpentine.sv @@
`default_nettype none

// Channel   Signals                                   Request
// item      item_valid, item_ready, item              one action
// pixel     pixel_valid, pixel_ready, pixel           one lit LED
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data one register write
//
// A two-entry queue decouples acceptance from execution; loads and pen moves are done as they are popped.
// A character reads its glyph entry, then steps through each glyph bit and each fetched byte;
// each lit pixel then passes the modulo states S_MOD0, S_MOD1 and the result hand-off.
// Reset clears control state and loads the config registers with defaults; the glyph and bitmap stores are not cleared.
// A stalled pixel output holds the walker, which in turn fills the queue.

module glyph_rasterizer_serpentine
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire grs_pkg::item_t item,
    output logic                pixel_valid,
    input  wire logic           pixel_ready,
    output grs_pkg::pixel_t     pixel,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [10:0]    cfg_data
);

    logic [5:0]  columns_reg;
    logic [5:0]  rows_reg;
    logic        cmajor_reg;
    logic [10:0] count_reg;
    logic [7:0]  first_reg;
    logic [7:0]  end_reg;
    logic        cfg_write;
    grs_pkg::panel_t  panel;
    grs_pkg::item_t   q_head;
    grs_pkg::status_t status;
    logic        q_valid, q_ready;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 6'd11;
            rows_reg    <= 6'd10;
            cmajor_reg  <= 1'b0;
            count_reg   <= 11'd110;
            first_reg   <= 8'd32;
            end_reg     <= 8'd127;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                grs_pkg::REG_COLUMNS: columns_reg <= cfg_data[5:0];
                grs_pkg::REG_ROWS:    rows_reg    <= cfg_data[5:0];
                grs_pkg::REG_CMAJOR:  cmajor_reg  <= cfg_data[0];
                grs_pkg::REG_COUNT:   count_reg   <= cfg_data;
                grs_pkg::REG_FIRST:   first_reg   <= cfg_data[7:0];
                grs_pkg::REG_END:     end_reg     <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        panel.columns      = columns_reg;
        panel.rows         = rows_reg;
        panel.column_major = cmajor_reg;
        if (count_reg == 11'd0)
        begin
            panel.modulus = 11'd1;
        end
        else if (count_reg > 11'd1024)
        begin
            panel.modulus = 11'd1024;
        end
        else
        begin
            panel.modulus = count_reg;
        end
    end

    grs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .first_code (first_reg),
        .end_code   (end_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_head     (q_head)
    );

    grs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_head      (q_head),
        .panel       (panel),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .status      (status)
    );

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> q_valid)
        else $error("queue full without a head entry");

    a_pop_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |-> !status.pend_valid)
        else $error("new request taken while a pixel is pending");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> !status.busy)
        else $error("back end ready while busy");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        grs_pkg::item_t req;
        bit             typed;
        logic [9:0]     index;
    } drill_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    grs_pkg::item_t  item = '0;
    logic       pixel_valid;
    logic       pixel_ready = 1'b0;
    grs_pkg::pixel_t pixel;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [10:0] cfg_data = '0;

    grs_pkg::glyph_t glyphs [grs_pkg::GLYPH_SLOTS];
    bit         glyph_known [grs_pkg::GLYPH_SLOTS];
    logic [7:0] bitmap [grs_pkg::BITMAP_BYTES];
    bit         byte_known [grs_pkg::BITMAP_BYTES];
    logic [7:0] pen_x, pen_y;
    logic [5:0] columns, rows;
    logic       column_major;
    logic [10:0] modulus;
    logic [7:0] first_code, end_code;

    grs_pkg::pixel_t lit_due [$];
    int         errors = 0;
    bit         calm = 1'b0;
    int         holds_asked = 0;
    int         holds_done = 0;
    int         hold_left = 0;

    glyph_rasterizer_serpentine dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("** glyph_rasterizer_serpentine: FAILED **");
        $finish;
    end

    function automatic logic [9:0] chain_index(logic [7:0] px, logic [7:0] py);
        int x, y, cols, rws, pos, n, r;
        x = int'($signed(px));
        y = int'($signed(py));
        cols = int'(columns);
        rws = int'(rows);
        if (!column_major)
            pos = py[0] ? x + y * cols : (cols - x - 1) + y * cols;
        else
            pos = px[0] ? (rws - y - 1) + x * rws : y + x * rws;
        n = int'(modulus);
        if (n < 1)
            n = 1;
        if (n > 1024)
            n = 1024;
        r = pos % n;
        if (r < 0)
            r += n;
        return r[9:0];
    endfunction

    function automatic bit in_font(logic [7:0] code);
        return code >= first_code && code < end_code;
    endfunction

    function automatic int slot_of(logic [7:0] code);
        return (int'(code) - int'(first_code)) % grs_pkg::GLYPH_SLOTS;
    endfunction

    // A font code is drawable only once its glyph entry and every byte it reads exist.
    function automatic bit drawable(logic [7:0] code);
        int s, w, h, n;
        if (!in_font(code))
            return 1'b1;
        s = slot_of(code);
        if (!glyph_known[s])
            return 1'b0;
        w = glyphs[s].width > 8 ? 8 : glyphs[s].width;
        h = glyphs[s].height > 8 ? 8 : glyphs[s].height;
        n = (w * h + 7) / 8;
        for (int k = 0; k < n; k++)
            if (!byte_known[(glyphs[s].offset + k) % grs_pkg::BITMAP_BYTES])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic render(input grs_pkg::item_t req, ref grs_pkg::pixel_t lit [$]);
        grs_pkg::glyph_t g;
        int w, h, addr;
        logic [7:0] bits, mask;
        grs_pkg::pixel_t p;
        lit.delete();
        case (req.action)
            grs_pkg::ACT_GLYPH:
            begin
                glyphs[req.table_address % grs_pkg::GLYPH_SLOTS] =
                    '{req.glyph_offset, req.glyph_width, req.glyph_height, req.glyph_advance};
                glyph_known[req.table_address % grs_pkg::GLYPH_SLOTS] = 1'b1;
            end
            grs_pkg::ACT_BYTE:
            begin
                bitmap[req.table_address] = req.bitmap_byte;
                byte_known[req.table_address] = 1'b1;
            end
            grs_pkg::ACT_PEN:
            begin
                pen_x = req.pen_column;
                pen_y = req.pen_row;
            end
            default:
            begin
                if (in_font(req.char_code))
                begin
                    g = glyphs[slot_of(req.char_code)];
                    w = g.width > 8 ? 8 : g.width;
                    h = g.height > 8 ? 8 : g.height;
                    addr = g.offset;
                    bits = '0;
                    mask = '0;
                    for (int r = 0; r < h; r++)
                        for (int c = 0; c < w; c++)
                        begin
                            if (mask == 0)
                            begin
                                bits = bitmap[addr];
                                addr = (addr + 1) % grs_pkg::BITMAP_BYTES;
                                mask = 8'h80;
                            end
                            if (bits & mask)
                            begin
                                p.led_index = chain_index(pen_x + 8'(c), pen_y + 8'(r));
                                p.led_color = req.pixel_color;
                                p.last_pixel = 1'b0;
                                lit.push_back(p);
                            end
                            mask = mask >> 1;
                        end
                    if (lit.size() > 0)
                        lit[lit.size() - 1].last_pixel = 1'b1;
                    pen_x = pen_x + 8'(g.advance);
                end
            end
        endcase
    endtask

    task automatic send(input grs_pkg::item_t req, input bit typed = 1'b0,
                        input logic [9:0] index = '0);
        grs_pkg::pixel_t lit [$];
        @(negedge clk);
        if (!calm && $urandom_range(99) < 30)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
        item <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        render(req, lit);
        if (typed)
            lit_due.push_back('{index, req.pixel_color, 1'b1});
        else
            foreach (lit[k])
                lit_due.push_back(lit[k]);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [10:0] data);
        @(negedge clk);
        item_valid <= 1'b0;
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            grs_pkg::REG_COLUMNS: columns = data[5:0];
            grs_pkg::REG_ROWS:    rows = data[5:0];
            grs_pkg::REG_CMAJOR:  column_major = data[0];
            grs_pkg::REG_COUNT:   modulus = data;
            grs_pkg::REG_FIRST:   first_code = data[7:0];
            grs_pkg::REG_END:     end_code = data[7:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        int quiet;
        quiet = 0;
        @(negedge clk);
        item_valid <= 1'b0;
        while (quiet < 400)
        begin
            @(negedge clk);
            quiet = lit_due.size() ? 0 : quiet + 1;
        end
    endtask

    function automatic grs_pkg::item_t mk(logic [1:0] act, logic [11:0] addr, logic [11:0] off,
                                 logic [3:0] w, logic [3:0] h, logic [3:0] adv,
                                 logic [7:0] data, logic [7:0] pc, logic [7:0] pr,
                                 logic [7:0] code, logic [23:0] color);
        grs_pkg::item_t x;
        x = '{act, addr, off, w, h, adv, data, pc, pr, code, color};
        return x;
    endfunction

    function automatic logic [7:0] pick_code();
        logic [7:0] code;
        if (first_code < end_code)
            for (int k = 0; k < 300; k++)
            begin
                code = 8'($urandom_range(int'(end_code) - 1, int'(first_code)));
                if (drawable(code))
                    return code;
            end
        return first_code > 0 ? first_code - 8'd1 : 8'd255;
    endfunction

    task automatic define_glyph();
        grs_pkg::item_t x;
        int n;
        x = grs_pkg::item_t'({$urandom, $urandom, $urandom});
        x.action = grs_pkg::ACT_GLYPH;
        if (first_code < end_code)
            x.table_address = 12'(slot_of(8'($urandom_range(int'(end_code) - 1,
                int'(first_code))))) + 12'(grs_pkg::GLYPH_SLOTS * $urandom_range(31));
        n = ((x.glyph_width > 8 ? 8 : x.glyph_width) *
             (x.glyph_height > 8 ? 8 : x.glyph_height) + 7) / 8;
        for (int k = 0; k < n; k++)
            send(mk(grs_pkg::ACT_BYTE, 12'((x.glyph_offset + k) % grs_pkg::BITMAP_BYTES),
                    12'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom)));
        send(x);
    endtask

    task automatic random_steps(input int steps);
        grs_pkg::item_t x;
        int pick;
        for (int s = 0; s < steps; s++)
        begin
            pick = $urandom_range(9);
            x = grs_pkg::item_t'({$urandom, $urandom, $urandom});
            if (pick <= 3)
                define_glyph();
            else
            begin
                if (pick == 4)
                    x.action = grs_pkg::ACT_PEN;
                else if (pick <= 8)
                begin
                    x.action = grs_pkg::ACT_DRAW;
                    x.char_code = pick_code();
                end
                if (x.action == grs_pkg::ACT_DRAW && !drawable(x.char_code))
                    x.char_code = first_code > 0 ? first_code - 8'd1 : 8'd255;
                if (x.action == grs_pkg::ACT_BYTE)
                    x.table_address = x.table_address;
                send(x);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                pixel_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (holds_asked != holds_done)
            begin
                pixel_ready <= 1'b0;
                hold_left <= 500;
                holds_done <= holds_asked;
            end
            else
                pixel_ready <= calm || $urandom_range(99) >= 30;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && pixel_ready)
        begin
            if (lit_due.size() == 0)
            begin
                $error("unexpected pixel index %0d", pixel.led_index);
                errors++;
            end
            else
            begin
                if (pixel.led_index !== lit_due[0].led_index)
                begin
                    $error("led_index expected %0d actual %0d",
                           lit_due[0].led_index, pixel.led_index);
                    errors++;
                end
                if (pixel.led_color !== lit_due[0].led_color)
                begin
                    $error("led_color expected %h actual %h",
                           lit_due[0].led_color, pixel.led_color);
                    errors++;
                end
                if (pixel.last_pixel !== lit_due[0].last_pixel)
                begin
                    $error("last_pixel expected %b actual %b",
                           lit_due[0].last_pixel, pixel.last_pixel);
                    errors++;
                end
                void'(lit_due.pop_front());
            end
        end
    end

    initial
    begin
        drill_t drill [$];
        pen_x = '0;
        pen_y = '0;
        columns = 6'd11;
        rows = 6'd10;
        column_major = 1'b0;
        modulus = 11'd110;
        first_code = 8'd32;
        end_code = 8'd127;
        foreach (glyph_known[k])
            glyph_known[k] = 1'b0;
        foreach (byte_known[k])
            byte_known[k] = 1'b0;

        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd0, 0, 0, 0, 0, 8'h80, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_GLYPH, 12'd0, 12'd0, 4'd1, 4'd1, 4'd1,
                             0, 0, 0, 0, 0), 0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd32, 24'hFFFFFF),
                          1, 10'd10});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd32, 24'h000000),
                          1, 10'd9});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd31, 24'h123456),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd127, 24'h123456),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0, 24'h123456),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd255, 24'h123456),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd4095, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd1, 0, 0, 0, 0, 8'h5A, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd2, 0, 0, 0, 0, 8'hA5, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd3, 0, 0, 0, 0, 8'h00, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd4, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd5, 0, 0, 0, 0, 8'h81, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_BYTE, 12'd6, 0, 0, 0, 0, 8'h7E, 0, 0, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_GLYPH, 12'd129, 12'd4095, 4'd15, 4'd15, 4'd15,
                             0, 0, 0, 0, 0), 0, 0});
        drill.push_back('{mk(grs_pkg::ACT_GLYPH, 12'd4095, 12'd4095, 4'd8, 4'd8, 4'd0,
                             0, 0, 0, 0, 0), 0, 0});
        drill.push_back('{mk(grs_pkg::ACT_GLYPH, 12'd2, 12'd1, 4'd0, 4'd8, 4'd3,
                             0, 0, 0, 0, 0), 0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd33, 24'hFF0000),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd34, 24'h00FF00),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_PEN, 0, 0, 0, 0, 0, 0, 8'h80, 8'h7F, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd33, 24'h0000FF),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_PEN, 0, 0, 0, 0, 0, 0, 8'h7F, 8'h80, 0, 0),
                          0, 0});
        drill.push_back('{mk(grs_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 8'd33, 24'hFFFFFF),
                          0, 0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (drill[k])
            send(drill[k].req, drill[k].typed, drill[k].index);
        random_steps(6);
        drain();

        write_reg(grs_pkg::REG_COLUMNS, 11'd1);
        write_reg(grs_pkg::REG_ROWS, 11'd1);
        write_reg(grs_pkg::REG_CMAJOR, 11'd1);
        write_reg(grs_pkg::REG_COUNT, 11'd1);
        write_reg(grs_pkg::REG_FIRST, 11'd0);
        write_reg(grs_pkg::REG_END, 11'd255);
        holds_asked++;
        random_steps(6);
        drain();

        write_reg(grs_pkg::REG_COLUMNS, 11'd32);
        write_reg(grs_pkg::REG_ROWS, 11'd32);
        write_reg(grs_pkg::REG_CMAJOR, 11'd0);
        write_reg(grs_pkg::REG_COUNT, 11'd1024);
        write_reg(grs_pkg::REG_END, 11'd128);
        calm = 1'b1;
        random_steps(6);
        calm = 1'b0;
        drain();

        write_reg(grs_pkg::REG_COLUMNS, 11'h7FF);
        write_reg(grs_pkg::REG_ROWS, 11'h7C0 | 11'd63);
        write_reg(grs_pkg::REG_CMAJOR, 11'h7FF);
        write_reg(grs_pkg::REG_COUNT, 11'd2047);
        write_reg(grs_pkg::REG_FIRST, 11'd200);
        write_reg(grs_pkg::REG_END, 11'd255);
        write_reg(3'd6, 11'h7FF);
        write_reg(3'd7, 11'h000);
        random_steps(6);
        drain();

        write_reg(grs_pkg::REG_COLUMNS, 11'd0);
        write_reg(grs_pkg::REG_ROWS, 11'd5);
        write_reg(grs_pkg::REG_CMAJOR, 11'd0);
        write_reg(grs_pkg::REG_COUNT, 11'd0);
        write_reg(grs_pkg::REG_FIRST, 11'd10);
        write_reg(grs_pkg::REG_END, 11'd100);
        random_steps(6);
        drain();

        if (errors == 0)
            $display("** glyph_rasterizer_serpentine: PASSED **");
        else
            $display("** glyph_rasterizer_serpentine: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
